// File: rtl/assert_macros.svh
// Assertion macros included by the element update core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHECK_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define CHECK_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/adamw_pkg.sv
// Types, constants and fixed-point multiply helpers for the AdamW update core.
`default_nettype none

package adamw_pkg;

   // Intermediate saturation bound, 2^61 LSB.
   localparam logic [63:0] LIM = 64'h2000_0000_0000_0000;

   typedef enum logic [3:0] {
      CSR_LEARNING_RATE   = 4'd0,
      CSR_BETA_FIRST      = 4'd1,
      CSR_BETA_SECOND     = 4'd2,
      CSR_EPSILON         = 4'd3,
      CSR_WEIGHT_DECAY    = 4'd4,
      CSR_CLIP_SCALE      = 4'd5,
      CSR_INV_BIAS_FIRST  = 4'd6,
      CSR_INV_BIAS_SECOND = 4'd7
   } csr_index_type;

   // Four 32-bit-split partial products of two magnitudes up to 2^61.
   typedef struct packed {
      logic        neg;
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } pp_type;

   // Values that ride along the sqrt and divide pipelines.
   typedef struct packed {
      logic signed [63:0] pd;
      logic signed [47:0] m1;
      logic [47:0]        m2;
      logic               last;
   } side_type;

   function automatic pp_type mul_pp(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
      pp_type      r;
      logic [63:0] ma;
      logic [63:0] mb;
      ma    = a[63] ? 64'(-a) : 64'(a);
      mb    = b[63] ? 64'(-b) : 64'(b);
      r.neg = a[63] ^ b[63];
      r.p00 = {32'b0, ma[31:0]} * {32'b0, mb[31:0]};
      r.p01 = {32'b0, ma[31:0]} * {34'b0, mb[61:32]};
      r.p10 = {34'b0, ma[61:32]} * {32'b0, mb[31:0]};
      r.p11 = {34'b0, ma[61:32]} * {34'b0, mb[61:32]};
      return r;
   endfunction

   function automatic logic [127:0] mul_sum(input pp_type x);
      return {64'b0, x.p00} + ({64'b0, x.p01} << 32) + ({64'b0, x.p10} << 32)
           + {x.p11, 64'b0};
   endfunction

   // Round half away from zero on the magnitude, saturate at 2^61, apply sign.
   function automatic logic signed [63:0] mul_fin(input pp_type x, input int frac);
      logic [127:0] full;
      logic [63:0]  r;
      full = mul_sum(x) + (128'd1 << (frac - 1));
      if ((full >> (64 + frac)) != 128'd0) r = LIM;
      else r = 64'(full >> frac);
      if (r > LIM) r = LIM;
      return x.neg ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -64'sh0000_8000_0000_0000) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

   function automatic logic [47:0] satu48(input logic signed [63:0] v);
      if (v < 64'sd0) return 48'd0;
      if (v > 64'sh0000_FFFF_FFFF_FFFF) return 48'hFFFF_FFFF_FFFF;
      return v[47:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/adamw_element_update_core.sv
// AdamW element update core: pipelined Q-format step, one element per cycle unless stalled.
`default_nettype none
`include "assert_macros.svh"

// 128 registers lie in the path from request transfer to result valid
// (9 multiply, 51 square-root, 3 denominator/product, 64 divide, output), first at transfer.
// Throughput: one element per cycle unless stalled; per-bit sqrt/divide pipelines set depth.
// A stalled result freezes the pipe; a one-entry skid keeps taking one transfer.
// Reset (synchronous, active high) clears valids and loads register defaults.

module adamw_element_update_core
   import adamw_pkg::*;
#(
   parameter int FRAC_BITS = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   // request channel
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire signed [47:0]   req_param_in,
   input  wire signed [47:0]   req_grad_in,
   input  wire signed [47:0]   req_moment_one_in,
   input  wire [47:0]          req_moment_two_in,
   input  wire                 req_last_in,
   // result channel
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic signed [47:0]  rsp_param_out,
   output logic signed [47:0]  rsp_moment_one_out,
   output logic [47:0]         rsp_moment_two_out,
   output logic                rsp_last_out,
   // register write channel
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire [3:0]           csr_index,
   input  wire [47:0]          csr_wdata
);

   localparam int LAT      = 128;          // total register stages
   localparam int SQ_STEPS = 51;           // root bits 50..0
   localparam int DV_STEPS = 64;           // quotient bits 63..0
   localparam int XW       = 62 + FRAC_BITS; // radicand width
   localparam int TW       = 104;          // trial width, covers XW + 2
   localparam int SQ_BASE  = 8;            // valid index of sqrt stage 0
   localparam int DV_BASE  = 62;           // valid index of divide stage 0
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [31:0] lr_ff, b1_ff, b2_ff, wd_ff;
   logic [47:0] eps_ff, ib1_ff, ib2_ff;
   logic [32:0] clip_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff   <= 32'd4294967;
         b1_ff   <= 32'd3865470566;
         b2_ff   <= 32'd4290672329;
         eps_ff  <= 48'd43;
         wd_ff   <= 32'd42949673;
         clip_ff <= 33'h1_0000_0000;
         ib1_ff  <= 48'h1_0000_0000;
         ib2_ff  <= 48'h1_0000_0000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LEARNING_RATE:   lr_ff   <= csr_wdata[31:0];
            CSR_BETA_FIRST:      b1_ff   <= csr_wdata[31:0];
            CSR_BETA_SECOND:     b2_ff   <= csr_wdata[31:0];
            CSR_EPSILON:         eps_ff  <= csr_wdata;
            CSR_WEIGHT_DECAY:    wd_ff   <= csr_wdata[31:0];
            CSR_CLIP_SCALE:      clip_ff <= csr_wdata[32:0];
            CSR_INV_BIAS_FIRST:  ib1_ff  <= csr_wdata;
            CSR_INV_BIAS_SECOND: ib2_ff  <= csr_wdata;
            default: ;           // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline advance and input skid
   // ---------------------------------------------------------------
   logic [LAT-1:0] vpipe_ff, vpipe_in;
   logic           adv;
   logic           skid_v_ff, skid_v_in;
   logic signed [47:0] skid_p_ff, skid_g_ff, skid_m1_ff;
   logic [47:0]        skid_m2_ff;
   logic               skid_last_ff;

   logic               in_v;
   logic signed [47:0] in_p, in_g, in_m1;
   logic [47:0]        in_m2;
   logic               in_last;

   // Whole pipe moves unless a finished result is held by the consumer.
   assign adv       = !(vpipe_ff[LAT-1] && rsp_stall);
   assign req_stall = skid_v_ff;
   assign rsp_valid = vpipe_ff[LAT-1];

   assign in_v    = skid_v_ff | req_valid;
   assign in_p    = skid_v_ff ? skid_p_ff    : req_param_in;
   assign in_g    = skid_v_ff ? skid_g_ff    : req_grad_in;
   assign in_m1   = skid_v_ff ? skid_m1_ff   : req_moment_one_in;
   assign in_m2   = skid_v_ff ? skid_m2_ff   : req_moment_two_in;
   assign in_last = skid_v_ff ? skid_last_ff : req_last_in;

   always_comb begin
      skid_v_in = skid_v_ff;
      if (adv) skid_v_in = 1'b0;
      else if (req_valid && !skid_v_ff) skid_v_in = 1'b1;
      vpipe_in = adv ? {vpipe_ff[LAT-2:0], in_v} : vpipe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
         vpipe_ff  <= '0;
      end else begin
         skid_v_ff <= skid_v_in;
         vpipe_ff  <= vpipe_in;
      end
   end

   // skid captures a transfer taken while the pipe is frozen
   always_ff @(posedge clock) begin
      if (!skid_v_ff && !adv) begin
         skid_p_ff    <= req_param_in;
         skid_g_ff    <= req_grad_in;
         skid_m1_ff   <= req_moment_one_in;
         skid_m2_ff   <= req_moment_two_in;
         skid_last_ff <= req_last_in;
      end
   end

   // ---------------------------------------------------------------
   // Multiply stages A..H: each product is partial products then round
   // ---------------------------------------------------------------
   pp_type a_g_pp_ff, a_b1_pp_ff, a_b2_pp_ff, a_lw_pp_ff;
   logic signed [47:0] a_p_ff;
   logic a_last_ff;

   logic signed [63:0] b_grad_ff, b_t1_ff, b_t2_ff, b_lrwd_ff;
   logic signed [47:0] b_p_ff;
   logic b_last_ff;

   pp_type c_t3_pp_ff, c_gg_pp_ff, c_pd_pp_ff;
   logic signed [63:0] c_t1_ff, c_t2_ff;
   logic c_last_ff;

   logic signed [63:0] d_t3_ff, d_gg_ff, d_pd_ff, d_t1_ff, d_t2_ff;
   logic d_last_ff;

   logic signed [47:0] e_m1_ff;
   pp_type e_t4_pp_ff;
   logic signed [63:0] e_t2_ff, e_pd_ff;
   logic e_last_ff;

   logic signed [63:0] f_t4_ff, f_t2_ff, f_pd_ff;
   pp_type f_c1_pp_ff;
   logic signed [47:0] f_m1_ff;
   logic f_last_ff;

   logic [47:0] g_m2_ff;
   logic signed [63:0] g_c1_ff, g_pd_ff;
   logic signed [47:0] g_m1_ff;
   logic g_last_ff;

   pp_type h_c2_pp_ff;
   logic signed [63:0] h_c1_ff;
   side_type h_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         // A: clip, moment decay and lr*wd partial products
         a_g_pp_ff  <= mul_pp(64'(in_g), {31'b0, clip_ff});
         a_b1_pp_ff <= mul_pp({32'b0, b1_ff}, 64'(in_m1));
         a_b2_pp_ff <= mul_pp({32'b0, b2_ff}, {16'b0, in_m2});
         a_lw_pp_ff <= mul_pp({32'b0, lr_ff}, {32'b0, wd_ff});
         a_p_ff     <= in_p;
         a_last_ff  <= in_last;
         // B
         b_grad_ff <= mul_fin(a_g_pp_ff, FRAC_BITS);
         b_t1_ff   <= mul_fin(a_b1_pp_ff, FRAC_BITS);
         b_t2_ff   <= mul_fin(a_b2_pp_ff, FRAC_BITS);
         b_lrwd_ff <= mul_fin(a_lw_pp_ff, FRAC_BITS);
         b_p_ff    <= a_p_ff;
         b_last_ff <= a_last_ff;
         // C: (1-b1)*g, g*g, p*(1-lr*wd)
         c_t3_pp_ff <= mul_pp(ONE - $signed({32'b0, b1_ff}), b_grad_ff);
         c_gg_pp_ff <= mul_pp(b_grad_ff, b_grad_ff);
         c_pd_pp_ff <= mul_pp(64'(b_p_ff), ONE - b_lrwd_ff);
         c_t1_ff    <= b_t1_ff;
         c_t2_ff    <= b_t2_ff;
         c_last_ff  <= b_last_ff;
         // D
         d_t3_ff   <= mul_fin(c_t3_pp_ff, FRAC_BITS);
         d_gg_ff   <= mul_fin(c_gg_pp_ff, FRAC_BITS);
         d_pd_ff   <= mul_fin(c_pd_pp_ff, FRAC_BITS);
         d_t1_ff   <= c_t1_ff;
         d_t2_ff   <= c_t2_ff;
         d_last_ff <= c_last_ff;
         // E: first moment done; (1-b2)*g^2
         e_m1_ff    <= sat48(d_t1_ff + d_t3_ff);
         e_t4_pp_ff <= mul_pp(ONE - $signed({32'b0, b2_ff}), d_gg_ff);
         e_t2_ff    <= d_t2_ff;
         e_pd_ff    <= d_pd_ff;
         e_last_ff  <= d_last_ff;
         // F: bias-correct first moment
         f_t4_ff    <= mul_fin(e_t4_pp_ff, FRAC_BITS);
         f_c1_pp_ff <= mul_pp(64'(e_m1_ff), {16'b0, ib1_ff});
         f_m1_ff    <= e_m1_ff;
         f_t2_ff    <= e_t2_ff;
         f_pd_ff    <= e_pd_ff;
         f_last_ff  <= e_last_ff;
         // G: second moment done
         g_m2_ff   <= satu48(f_t2_ff + f_t4_ff);
         g_c1_ff   <= mul_fin(f_c1_pp_ff, FRAC_BITS);
         g_m1_ff   <= f_m1_ff;
         g_pd_ff   <= f_pd_ff;
         g_last_ff <= f_last_ff;
         // H: bias-correct second moment
         h_c2_pp_ff       <= mul_pp({16'b0, g_m2_ff}, {16'b0, ib2_ff});
         h_c1_ff          <= g_c1_ff;
         h_side_ff.pd     <= g_pd_ff;
         h_side_ff.m1     <= g_m1_ff;
         h_side_ff.m2     <= g_m2_ff;
         h_side_ff.last   <= g_last_ff;
      end
   end

   // ---------------------------------------------------------------
   // Square root: one result bit per stage, remainder form
   // ---------------------------------------------------------------
   logic [XW-1:0]      sq_rem_ff  [0:SQ_STEPS];
   logic [50:0]        sq_root_ff [0:SQ_STEPS];
   logic signed [63:0] sq_c1_ff   [0:SQ_STEPS];
   side_type           sq_side_ff [0:SQ_STEPS];

   logic signed [63:0] c2_full;
   logic [61:0]        c2_sat;

   always_comb begin
      c2_full = mul_fin(h_c2_pp_ff, FRAC_BITS);
      if (c2_full < 64'sd0) c2_sat = 62'd0;
      else if (c2_full > $signed(LIM)) c2_sat = LIM[61:0];
      else c2_sat = c2_full[61:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= XW'(c2_sat) << FRAC_BITS;
         sq_root_ff[0] <= '0;
         sq_c1_ff[0]   <= h_c1_ff;
         sq_side_ff[0] <= h_side_ff;
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam int B = SQ_STEPS - 1 - k;
      logic [TW-1:0] trial;
      logic [TW-1:0] rem_w;
      logic          take;
      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
      assign trial = ({{(TW-51){1'b0}}, sq_root_ff[k]} << (B + 1)) + (TW'(1) << (2 * B));
      assign rem_w = {{(TW-XW){1'b0}}, sq_rem_ff[k]};
      assign take  = rem_w >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k+1]  <= take ? XW'(rem_w - trial) : sq_rem_ff[k];
            sq_root_ff[k+1] <= take ? (sq_root_ff[k] | (51'd1 << B)) : sq_root_ff[k];
            sq_c1_ff[k+1]   <= sq_c1_ff[k];
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // J: round root; K: denominator and |c1|*lr; L: dividend set-up
   // ---------------------------------------------------------------
   logic [51:0]        j_root_ff;
   logic signed [63:0] j_c1_ff;
   side_type           j_side_ff;

   logic [52:0]        k_den_ff;
   pp_type             k_pp_ff;
   side_type           k_side_ff;

   logic [52:0] den_w;
   logic [127:0] num_w;

   always_comb begin
      den_w = 53'(j_root_ff) + 53'(eps_ff);
      if (den_w == 53'd0) den_w = 53'd1;      // zero denominator taken as one LSB
      num_w = mul_sum(k_pp_ff) + 128'(k_den_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // round to nearest: remainder above root means x > r*(r+1)
         j_root_ff <= 52'(sq_root_ff[SQ_STEPS])
                    + 52'(XW'(sq_rem_ff[SQ_STEPS]) > XW'(sq_root_ff[SQ_STEPS]));
         j_c1_ff   <= sq_c1_ff[SQ_STEPS];
         j_side_ff <= sq_side_ff[SQ_STEPS];
         k_den_ff  <= den_w;
         k_pp_ff   <= mul_pp(j_c1_ff, {32'b0, lr_ff});
         k_side_ff <= j_side_ff;
      end
   end

   // ---------------------------------------------------------------
   // Division: one quotient bit per stage
   // ---------------------------------------------------------------
   logic [52:0]  dv_rem_ff  [0:DV_STEPS];
   logic [63:0]  dv_q_ff    [0:DV_STEPS];
   logic [63:0]  dv_lo_ff   [0:DV_STEPS];
   logic [52:0]  dv_den_ff  [0:DV_STEPS];
   logic         dv_ovf_ff  [0:DV_STEPS];
   logic         dv_neg_ff  [0:DV_STEPS];
   side_type     dv_side_ff [0:DV_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0]  <= num_w[116:64];
         dv_q_ff[0]    <= '0;
         dv_lo_ff[0]   <= num_w[63:0];
         dv_den_ff[0]  <= k_den_ff;
         dv_ovf_ff[0]  <= num_w[127:64] >= 64'(k_den_ff);
         dv_neg_ff[0]  <= k_pp_ff.neg;
         dv_side_ff[0] <= k_side_ff;
      end
   end

   for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
      logic [53:0] rs;
      logic        take;
      assign rs   = {dv_rem_ff[k], dv_lo_ff[k][DV_STEPS-1-k]};
      assign take = rs >= {1'b0, dv_den_ff[k]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[k+1]  <= take ? 53'(rs - {1'b0, dv_den_ff[k]}) : rs[52:0];
            dv_q_ff[k+1]    <= {dv_q_ff[k][62:0], take};
            dv_lo_ff[k+1]   <= dv_lo_ff[k];
            dv_den_ff[k+1]  <= dv_den_ff[k];
            dv_ovf_ff[k+1]  <= dv_ovf_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_side_ff[k+1] <= dv_side_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Output stage: saturate step, subtract from decayed parameter
   // ---------------------------------------------------------------
   logic [63:0]        q_mag;
   logic signed [63:0] q_sgn;
   logic signed [47:0] out_p_ff, out_m1_ff;
   logic [47:0]        out_m2_ff;
   logic               out_last_ff;

   always_comb begin
      q_mag = dv_q_ff[DV_STEPS];
      if (dv_ovf_ff[DV_STEPS] || q_mag > LIM) q_mag = LIM;
      q_sgn = dv_neg_ff[DV_STEPS] ? -$signed(q_mag) : $signed(q_mag);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_p_ff    <= sat48(dv_side_ff[DV_STEPS].pd - q_sgn);
         out_m1_ff   <= dv_side_ff[DV_STEPS].m1;
         out_m2_ff   <= dv_side_ff[DV_STEPS].m2;
         out_last_ff <= dv_side_ff[DV_STEPS].last;
      end
   end

   assign rsp_param_out      = out_p_ff;
   assign rsp_moment_one_out = out_m1_ff;
   assign rsp_moment_two_out = out_m2_ff;
   assign rsp_last_out       = out_last_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // integer sqrt leaves a remainder no larger than twice the root
   `CHECK_IMPLY(a_sqrt_rem, clock, reset, vpipe_ff[SQ_BASE + SQ_STEPS],
      {1'b0, sq_rem_ff[SQ_STEPS]} <= ({(XW+1)'(sq_root_ff[SQ_STEPS])} << 1))
   // divider remainder stays below the denominator
   `CHECK_IMPLY(a_div_rem, clock, reset,
      vpipe_ff[DV_BASE + DV_STEPS] && !dv_ovf_ff[DV_STEPS],
      dv_rem_ff[DV_STEPS] < dv_den_ff[DV_STEPS])
   // a frozen pipe keeps its valids and its skid entry
   `CHECK_NEXT(a_freeze, clock, reset, !adv,
      $stable(vpipe_ff) && (skid_v_ff || !$past(skid_v_ff)))

endmodule

`default_nettype wire
